// ===== hdl/dta_pkg.sv =====
// Package for the binary to decimal ASCII converter.
// Holds the shared constants, the cell control word and the controller state type.
// No dependencies.
package dta_pkg;

  localparam int FIELD_W = 64;
  localparam int LEN_W = 5;
  localparam int CHAR_W = 8;
  localparam int DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic clear;
    logic bit_shift;
    logic digit_shift;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

// ===== hdl/dta_in_if.sv =====
// Input channel interface of the decimal ASCII converter.
// Carries one binary word and its signedness flag; uses dta_pkg.
interface dta_in_if;
  logic valid;
  logic ready;
  logic [dta_pkg::FIELD_W-1:0] value;
  logic is_signed;

  modport source(output valid, output value, output is_signed, input ready);
  modport sink(input valid, input value, input is_signed, output ready);
endinterface

// ===== hdl/dta_out_if.sv =====
// Output channel interface of the decimal ASCII converter.
// Carries one text character with the text length and a last flag; uses dta_pkg.
interface dta_out_if;
  logic valid;
  logic ready;
  dta_pkg::char_t text_char;
  dta_pkg::len_t text_length;
  logic last;

  modport source(output valid, output text_char, output text_length, output last,
                 input ready);
  modport sink(input valid, input text_char, input text_length, input last,
               output ready);
endinterface

// ===== hdl/dta_cell.sv =====
// One BCD digit cell of the double-dabble chain.
// Clears to zero, shifts in one binary bit, or takes the whole digit of its lower neighbor; uses dta_pkg.
module dta_cell (
  input  logic                clk,
  input  dta_pkg::cell_ctrl_t ctrl,
  input  logic                bit_in,
  input  dta_pkg::digit_t     digit_in,
  output logic                bit_out,
  output dta_pkg::digit_t     digit
);
  import dta_pkg::*;

  digit_t digit_r;
  digit_t digit_nxt;
  digit_t adj;

  always_comb begin
    adj = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
    priority if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.bit_shift) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.digit_shift) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign bit_out = adj[3];
  assign digit = digit_r;

endmodule

// ===== hdl/dta_ctrl.sv =====
// Sequencer of the decimal ASCII converter.
// Forms the magnitude, feeds it bit by bit into the digit chain, then emits the text.
// Uses dta_pkg and the two channel interfaces.
module dta_ctrl #(
  parameter int VALUE_WIDTH = 64,
  parameter int NDIG = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  dta_in_if.sink              in_if,
  dta_out_if.source           out_if,
  input  dta_pkg::digit_t     digits [NDIG],
  output dta_pkg::cell_ctrl_t cell_ctrl,
  output logic                ser_bit
);
  import dta_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int ND_W = $clog2(NDIG + 1);
  localparam int IDX_W = $clog2(NDIG);

  state_t state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [VALUE_WIDTH-1:0] word;
  logic neg_r, neg_nxt;
  logic word_neg;
  logic sign_pend_r, sign_pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ND_W-1:0] ndig_r, ndig_nxt;
  logic [ND_W-1:0] dcnt_r, dcnt_nxt;
  logic [IDX_W-1:0] top_idx;
  digit_t top_digit;
  logic ov_r, ov_nxt;
  char_t char_r, char_nxt;
  len_t len_r, len_nxt;
  logic last_r, last_nxt;

  always_comb begin
    word = in_if.value[VALUE_WIDTH-1:0];
    word_neg = in_if.is_signed & word[VALUE_WIDTH-1];
    top_idx = IDX_W'(ndig_r - ND_W'(1));
    top_digit = digits[top_idx];

    state_nxt = state_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    sign_pend_nxt = sign_pend_r;
    cnt_nxt = cnt_r;
    ndig_nxt = ndig_r;
    dcnt_nxt = dcnt_r;
    ov_nxt = ov_r;
    char_nxt = char_r;
    len_nxt = len_r;
    last_nxt = last_r;
    cell_ctrl = '0;

    if (ov_r && out_if.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          cell_ctrl.clear = 1'b1;
          mag_nxt = word_neg ? (~word + VALUE_WIDTH'(1)) : word;
          neg_nxt = word_neg;
          sign_pend_nxt = word_neg;
          cnt_nxt = CNT_W'(VALUE_WIDTH);
          ndig_nxt = ND_W'(1);
          dcnt_nxt = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_ctrl.bit_shift = 1'b1;
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (top_digit >= 4'd5 && ndig_r < ND_W'(NDIG)) begin
          ndig_nxt = ndig_r + ND_W'(1);
        end
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt = 1'b1;
          len_nxt = LEN_W'(ndig_r) + LEN_W'(neg_r);
          if (sign_pend_r) begin
            char_nxt = CHAR_MINUS;
            last_nxt = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            char_nxt = CHAR_ZERO + {4'b0000, top_digit};
            cell_ctrl.digit_shift = 1'b1;
            dcnt_nxt = dcnt_r + ND_W'(1);
            last_nxt = (dcnt_r == ndig_r - ND_W'(1));
            if (dcnt_r == ndig_r - ND_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    sign_pend_r <= sign_pend_nxt;
    cnt_r <= cnt_nxt;
    ndig_r <= ndig_nxt;
    dcnt_r <= dcnt_nxt;
    char_r <= char_nxt;
    len_r <= len_nxt;
    last_r <= last_nxt;
  end

  assign ser_bit = mag_r[VALUE_WIDTH-1];
  assign in_if.ready = (state_r == ST_IDLE);
  assign out_if.valid = ov_r;
  assign out_if.text_char = char_r;
  assign out_if.text_length = len_r;
  assign out_if.last = last_r;

endmodule

// ===== hdl/int64_to_decimal_ascii_top.sv =====
// Binary word to decimal ASCII text, one character per output word.
// Sequence: the word is accepted, its bits are shifted through the BCD cell chain, then the
// first character follows; one character per cycle after that when the sink is ready.
// A new input word is accepted only after the last character of the text is loaded for output.
// Reset: synchronous active-low rst_n clears the sequencer and the output valid.
module int64_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  dta_in_if.sink    in_if,
  dta_out_if.source out_if
);
  import dta_pkg::*;

  localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;

  cell_ctrl_t cell_ctrl;
  logic ser_bit;
  digit_t digits [NDIG];
  logic carry [NDIG];

  dta_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NDIG(NDIG)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if),
    .digits(digits),
    .cell_ctrl(cell_ctrl),
    .ser_bit(ser_bit)
  );

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    if (i == 0) begin : g_first
      dta_cell u_cell (
        .clk(clk),
        .ctrl(cell_ctrl),
        .bit_in(ser_bit),
        .digit_in('0),
        .bit_out(carry[i]),
        .digit(digits[i])
      );
    end else begin : g_next
      dta_cell u_cell (
        .clk(clk),
        .ctrl(cell_ctrl),
        .bit_in(carry[i-1]),
        .digit_in(digits[i-1]),
        .bit_out(carry[i]),
        .digit(digits[i])
      );
    end
  end

endmodule

// ===== hdl/dta_checker.sv =====
// Port-level checks for the decimal ASCII converter.
// Bound to int64_to_decimal_ascii_top; uses dta_pkg.
module dta_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input dta_pkg::char_t  text_char,
  input dta_pkg::len_t   text_length,
  input logic            last
);
  import dta_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (text_length >= 5'd1 && text_length <= 5'd20))
    else $error("text length out of range");

  a_text_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=> out_valid && $stable(text_length))
    else $error("text broken off before its last character");

  a_busy_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> !in_ready)
    else $error("input ready in the middle of a text");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(text_char))
    else $error("stalled output word changed");

endmodule

bind int64_to_decimal_ascii_top dta_checker u_dta_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_if.valid),
  .in_ready(in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .text_char(out_if.text_char),
  .text_length(out_if.text_length),
  .last(out_if.last)
);
